// File: rtl/core/fsp_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package fsp_pkg;

   localparam int unsigned PAGE_WORDS_DEF = 64;
   localparam int unsigned ADDR_W = 24;

   // input item kinds
   localparam logic [1:0] KIND_CTRL = 2'd0;
   localparam logic [1:0] KIND_LPM  = 2'd1;
   localparam logic [1:0] KIND_SPM  = 2'd2;
   localparam logic [1:0] KIND_TICK = 2'd3;

   // result kinds
   localparam logic [1:0] RK_OVERRIDE   = 2'd0;
   localparam logic [1:0] RK_FLASH_READ = 2'd1;
   localparam logic [1:0] RK_WORD_WRITE = 2'd2;

   // control register bit positions
   localparam int unsigned CB_ENABLE  = 0;
   localparam int unsigned CB_ERASE   = 1;
   localparam int unsigned CB_WRITE   = 2;
   localparam int unsigned CB_LOCKSET = 3;
   localparam int unsigned CB_RWW     = 4;
   localparam int unsigned CB_SIGREAD = 5;

   localparam logic [2:0] ARM_TICKS = 3'd4;
   localparam logic [7:0] OSC_CAL   = 8'h55;

   localparam logic [ADDR_W-1:0] SERIAL_FIRST = 24'h00000E;
   localparam logic [ADDR_W-1:0] SERIAL_FINAL = 24'h000017;
   localparam logic [3:0] SERIAL_ORDER [10] = '{
      4'd1, 4'd0, 4'd3, 4'd2, 4'd5, 4'd4, 4'd0, 4'd6, 4'd7, 4'd8
   };

   typedef struct packed {
      logic [7:0]  fuse_low;
      logic [7:0]  fuse_high;
      logic [7:0]  fuse_extended;
      logic [7:0]  lock_byte;
      logic [23:0] device_signature;
      logic [63:0] serial_low_bytes;
      logic [15:0] serial_high_bytes;
      logic        has_rww_section;
   } fsp_cfg_type;

   typedef struct packed {
      logic accept;      // latch the item and snapshot the control bits
      logic ctrl_write;
      logic tick;
      logic clear_en;    // LPM or SPM drops the enable bit
      logic rem_step;
      logic lpm_load;
      logic base_load;
      logic slot_fill;
      logic emit_load;
      logic emit_erase;
      logic temp_clear;
   } fsp_cmd_type;

   typedef struct packed {
      logic [7:0] ctrl_bits;
      logic       has_rww;
      logic       rem_last;
      logic       out_free;
      logic       emit_last;
   } fsp_stat_type;

endpackage
`default_nettype wire

// File: rtl/core/fsp_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
module fsp_ctrl (
   input  wire                 clock,
   input  wire                 reset,
   input  wire                 req_valid,
   input  wire [1:0]           req_kind,
   output logic                req_ready,
   output fsp_pkg::fsp_cmd_type cmd,
   input  fsp_pkg::fsp_stat_type stat
);
   import fsp_pkg::*;

   typedef enum logic [2:0] {
      S_IDLE,
      S_LPM,
      S_REM,
      S_SETUP,
      S_EMIT
   } state_type;

   typedef enum logic [1:0] {
      OP_ERASE,
      OP_WRITE,
      OP_FILL
   } op_type;

   state_type state_ff, state_in;
   op_type    op_ff, op_in;
   logic      take;

   assign req_ready = (state_ff == S_IDLE);
   assign take      = req_valid && req_ready;

   always_comb begin
      state_in = state_ff;
      op_in    = op_ff;
      cmd      = '0;
      unique case (state_ff)
         S_IDLE: begin
            if (take) begin
               cmd.accept = 1'b1;
               unique case (req_kind)
                  KIND_CTRL: cmd.ctrl_write = 1'b1;
                  KIND_TICK: cmd.tick = 1'b1;
                  KIND_LPM: begin
                     cmd.clear_en = 1'b1;
                     state_in     = S_LPM;
                  end
                  KIND_SPM: begin
                     cmd.clear_en = 1'b1;
                     if (stat.ctrl_bits[CB_ENABLE]) begin
                        if (stat.ctrl_bits[CB_ERASE]) begin
                           op_in    = OP_ERASE;
                           state_in = S_EMIT;
                        end else if (stat.ctrl_bits[CB_WRITE]) begin
                           op_in    = OP_WRITE;
                           state_in = S_REM;
                        end else if (stat.ctrl_bits[CB_LOCKSET]) begin
                           // lock bit setting: drop
                        end else if (stat.has_rww && stat.ctrl_bits[CB_RWW]) begin
                           cmd.temp_clear = 1'b1;
                        end else begin
                           op_in    = OP_FILL;
                           state_in = S_REM;
                        end
                     end
                  end
                  default: ;
               endcase
            end
         end
         S_LPM: begin
            cmd.lpm_load = stat.out_free;
            if (stat.out_free) state_in = S_IDLE;
         end
         S_REM: begin
            cmd.rem_step = 1'b1;
            if (stat.rem_last) state_in = S_SETUP;
         end
         S_SETUP: begin
            if (op_ff == OP_WRITE) begin
               cmd.base_load = 1'b1;
               state_in      = S_EMIT;
            end else begin
               cmd.slot_fill = 1'b1;
               state_in      = S_IDLE;
            end
         end
         S_EMIT: begin
            cmd.emit_load  = stat.out_free;
            cmd.emit_erase = (op_ff == OP_ERASE);
            if (stat.out_free && stat.emit_last) begin
               cmd.temp_clear = (op_ff == OP_WRITE);
               state_in       = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         op_ff    <= OP_FILL;
      end else begin
         state_ff <= state_in;
         op_ff    <= op_in;
      end
   end

endmodule
`default_nettype wire

// File: rtl/core/fsp_dpath.sv
`timescale 1ns / 1ps
`default_nettype none
module fsp_dpath #(
   parameter int unsigned PAGE_WORDS = fsp_pkg::PAGE_WORDS_DEF
) (
   input  wire                    clock,
   input  wire                    reset,
   input  wire [7:0]              req_ctrl_value,
   input  wire [23:0]             req_z_address,
   input  wire [15:0]             req_r01_word,
   input  fsp_pkg::fsp_cfg_type   cfg,
   input  fsp_pkg::fsp_cmd_type   cmd,
   output fsp_pkg::fsp_stat_type  stat,
   input  wire                    rsp_ready,
   output logic                   rsp_valid,
   output logic [1:0]             rsp_result_kind,
   output logic [7:0]             rsp_read_byte,
   output logic [23:0]            rsp_flash_address,
   output logic [15:0]            rsp_write_word,
   output logic                   rsp_last
);
   import fsp_pkg::*;

   localparam int unsigned IDX_W = $clog2(PAGE_WORDS);
   localparam int unsigned REM_W = IDX_W + 2;
   localparam logic [REM_W-1:0] DIVISOR = REM_W'(2 * PAGE_WORDS);
   localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(PAGE_WORDS - 1);

   // control state
   logic [7:0]  control_bits_ff;
   logic [2:0]  countdown_ff;

   // latched item
   logic [7:0]        cb_ff;
   logic [ADDR_W-1:0] z_ff;
   logic [ADDR_W-1:0] zsh_ff;
   logic [15:0]       r01_ff;

   // remainder of Z by twice the page size, one byte a cycle
   logic [REM_W-1:0]  rem_ff, rem_in;
   logic [1:0]        rem_cnt_ff;

   // page stream
   logic [ADDR_W-1:0] addr_ff;
   logic [IDX_W-1:0]  idx_ff, idx_in;
   logic [IDX_W-1:0]  slot;

   // temp buffer
   logic [15:0]           page_mem [PAGE_WORDS];
   logic [15:0]           rd_ff;
   logic [PAGE_WORDS-1:0] used_ff;

   // output register
   logic              out_valid_ff;
   logic [1:0]        out_kind_ff;
   logic [7:0]        out_byte_ff;
   logic [ADDR_W-1:0] out_addr_ff;
   logic [15:0]       out_word_ff;
   logic              out_last_ff;

   logic              out_free;
   logic              lpm_hit;
   logic [7:0]        lpm_byte;
   logic [3:0]        serial_pos;
   logic [3:0]        serial_num;
   logic [15:0]       emit_word;

   function automatic logic [REM_W-1:0] rem_byte(input logic [REM_W-1:0] r,
                                                 input logic [7:0] b);
      logic [REM_W-1:0] t;
      t = r;
      for (int i = 7; i >= 0; i--) begin
         t = {t[REM_W-2:0], b[i]};
         if (t >= DIVISOR) t = t - DIVISOR;
      end
      return t;
   endfunction

   assign out_free = !out_valid_ff || rsp_ready;
   assign slot     = rem_ff[IDX_W:1];
   assign rem_in   = rem_byte(rem_ff, zsh_ff[ADDR_W-1 -: 8]);

   assign stat.ctrl_bits = control_bits_ff;
   assign stat.has_rww   = cfg.has_rww_section;
   assign stat.rem_last  = (rem_cnt_ff == 2'd2);
   assign stat.out_free  = out_free;
   assign stat.emit_last = (idx_ff == IDX_LAST);

   // control bits and enable timeout
   always_ff @(posedge clock) begin
      if (reset) begin
         control_bits_ff <= '0;
         countdown_ff    <= '0;
      end else if (cmd.ctrl_write) begin
         control_bits_ff <= req_ctrl_value;
         if (req_ctrl_value[CB_ENABLE]) countdown_ff <= ARM_TICKS;
      end else if (cmd.tick) begin
         if (countdown_ff != 3'd0) begin
            countdown_ff <= countdown_ff - 3'd1;
            if (countdown_ff == 3'd1) control_bits_ff[CB_ENABLE] <= 1'b0;
         end
      end else if (cmd.clear_en) begin
         if (control_bits_ff[CB_ENABLE]) countdown_ff <= '0;
         control_bits_ff[CB_ENABLE] <= 1'b0;
      end
   end

   // item latch, remainder and address
   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         cb_ff   <= control_bits_ff;
         z_ff    <= req_z_address;
         zsh_ff  <= req_z_address;
         r01_ff  <= req_r01_word;
         addr_ff <= {req_z_address[ADDR_W-1:1], 1'b0};
      end else begin
         if (cmd.rem_step) zsh_ff <= {zsh_ff[ADDR_W-9:0], 8'h00};
         if (cmd.base_load) addr_ff <= z_ff - ADDR_W'(rem_ff);
         else if (cmd.emit_load) addr_ff <= addr_ff + 24'd2;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rem_ff     <= '0;
         rem_cnt_ff <= '0;
      end else if (cmd.accept) begin
         rem_ff     <= '0;
         rem_cnt_ff <= '0;
      end else if (cmd.rem_step) begin
         rem_ff     <= rem_in;
         rem_cnt_ff <= rem_cnt_ff + 2'd1;
      end
   end

   // read index runs one step ahead so rd_ff always matches idx_ff
   always_comb begin
      idx_in = idx_ff;
      if (cmd.accept) idx_in = '0;
      else if (cmd.emit_load && !stat.emit_last) idx_in = idx_ff + IDX_W'(1);
   end

   always_ff @(posedge clock) begin
      if (reset) idx_ff <= '0;
      else idx_ff <= idx_in;
   end

   always_ff @(posedge clock) begin
      if (cmd.slot_fill && !used_ff[slot]) page_mem[slot] <= r01_ff;
      rd_ff <= page_mem[idx_in];
   end

   always_ff @(posedge clock) begin
      if (reset || cmd.temp_clear) used_ff <= '0;
      else if (cmd.slot_fill) used_ff[slot] <= 1'b1;
   end

   // LPM override byte
   always_comb begin
      lpm_hit    = 1'b0;
      lpm_byte   = 8'h00;
      serial_pos = 4'(z_ff[4:0] - SERIAL_FIRST[4:0]);
      serial_num = SERIAL_ORDER[serial_pos];
      if (cb_ff[CB_ENABLE]) begin
         if (cb_ff[CB_LOCKSET]) begin
            lpm_hit = 1'b1;
            case (z_ff)
               24'd0:   lpm_byte = cfg.fuse_low;
               24'd1:   lpm_byte = cfg.lock_byte;
               24'd2:   lpm_byte = cfg.fuse_extended;
               24'd3:   lpm_byte = cfg.fuse_high;
               default: lpm_hit  = 1'b0;
            endcase
         end else if (cb_ff[CB_SIGREAD]) begin
            lpm_hit = 1'b1;
            if (z_ff == 24'd0) lpm_byte = cfg.device_signature[7:0];
            else if (z_ff == 24'd2) lpm_byte = cfg.device_signature[15:8];
            else if (z_ff == 24'd4) lpm_byte = cfg.device_signature[23:16];
            else if (z_ff == 24'd1) lpm_byte = OSC_CAL;
            else if (z_ff >= SERIAL_FIRST && z_ff <= SERIAL_FINAL) begin
               if (!serial_num[3])
                  lpm_byte = cfg.serial_low_bytes[{serial_num[2:0], 3'b000} +: 8];
               else
                  lpm_byte = cfg.serial_high_bytes[{serial_num[0], 3'b000} +: 8];
            end else lpm_hit = 1'b0;
         end
      end
   end

   assign emit_word = (cmd.emit_erase || !used_ff[idx_ff]) ? 16'hFFFF : rd_ff;

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (cmd.lpm_load || cmd.emit_load) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.lpm_load) begin
         out_kind_ff <= lpm_hit ? RK_OVERRIDE : RK_FLASH_READ;
         out_byte_ff <= lpm_byte;
         out_addr_ff <= '0;
         out_word_ff <= '0;
         out_last_ff <= 1'b1;
      end else if (cmd.emit_load) begin
         out_kind_ff <= RK_WORD_WRITE;
         out_byte_ff <= '0;
         out_addr_ff <= addr_ff;
         out_word_ff <= emit_word;
         out_last_ff <= stat.emit_last;
      end
   end

   assign rsp_valid         = out_valid_ff;
   assign rsp_result_kind   = out_kind_ff;
   assign rsp_read_byte     = out_byte_ff;
   assign rsp_flash_address = out_addr_ff;
   assign rsp_write_word    = out_word_ff;
   assign rsp_last          = out_last_ff;

endmodule
`default_nettype wire

// File: rtl/core/flash_self_program_controller_core.sv
// Control writes and ticks: taken without leaving idle, no result beat.
// LPM: one beat, loaded from S_LPM into the result register once it is free. SPM fill:
// the remainder unit in S_REM, then the temp buffer write port in S_SETUP.
// SPM erase: PAGE_WORDS beats from S_EMIT, one per cycle while the receiver keeps up;
// SPM page write: address setup in S_REM and S_SETUP, then PAGE_WORDS beats as for erase.
// Reset clears control bits, timeout, slot-used flags and the result valid flag.
`timescale 1ns / 1ps
`default_nettype none
module flash_self_program_controller_core #(
   parameter int unsigned PAGE_WORDS = fsp_pkg::PAGE_WORDS_DEF
) (
   input  wire         clock,
   input  wire         reset,
   input  wire         req_valid,
   output logic        req_ready,
   input  wire [1:0]   req_kind,
   input  wire [7:0]   req_ctrl_value,
   input  wire [23:0]  req_z_address,
   input  wire [15:0]  req_r01_word,
   output logic        rsp_valid,
   input  wire         rsp_ready,
   output logic [1:0]  rsp_result_kind,
   output logic [7:0]  rsp_read_byte,
   output logic [23:0] rsp_flash_address,
   output logic [15:0] rsp_write_word,
   output logic        rsp_last,
   input  wire         csr_psel,
   input  wire         csr_penable,
   input  wire         csr_pwrite,
   input  wire [5:0]   csr_paddr,
   input  wire [63:0]  csr_pwdata,
   output logic [63:0] csr_prdata,
   output logic        csr_pready
);
   import fsp_pkg::*;

   localparam logic [2:0] CSR_FUSE_LOW   = 3'd0;
   localparam logic [2:0] CSR_FUSE_HIGH  = 3'd1;
   localparam logic [2:0] CSR_FUSE_EXT   = 3'd2;
   localparam logic [2:0] CSR_LOCK       = 3'd3;
   localparam logic [2:0] CSR_SIGNATURE  = 3'd4;
   localparam logic [2:0] CSR_SERIAL_LO  = 3'd5;
   localparam logic [2:0] CSR_SERIAL_HI  = 3'd6;
   localparam logic [2:0] CSR_HAS_RWW    = 3'd7;

   fsp_cfg_type  cfg_ff;
   fsp_cmd_type  cmd;
   fsp_stat_type stat;
   logic         csr_wr;
   logic [2:0]   csr_idx;

   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_idx    = csr_paddr[5:3];

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.fuse_low          <= 8'hFF;
         cfg_ff.fuse_high         <= 8'hFF;
         cfg_ff.fuse_extended     <= 8'hFF;
         cfg_ff.lock_byte         <= 8'hFF;
         cfg_ff.device_signature  <= '0;
         cfg_ff.serial_low_bytes  <= '0;
         cfg_ff.serial_high_bytes <= '0;
         cfg_ff.has_rww_section   <= 1'b0;
      end else if (csr_wr) begin
         unique case (csr_idx)
            CSR_FUSE_LOW:  cfg_ff.fuse_low          <= csr_pwdata[7:0];
            CSR_FUSE_HIGH: cfg_ff.fuse_high         <= csr_pwdata[7:0];
            CSR_FUSE_EXT:  cfg_ff.fuse_extended     <= csr_pwdata[7:0];
            CSR_LOCK:      cfg_ff.lock_byte         <= csr_pwdata[7:0];
            CSR_SIGNATURE: cfg_ff.device_signature  <= csr_pwdata[23:0];
            CSR_SERIAL_LO: cfg_ff.serial_low_bytes  <= csr_pwdata;
            CSR_SERIAL_HI: cfg_ff.serial_high_bytes <= csr_pwdata[15:0];
            CSR_HAS_RWW:   cfg_ff.has_rww_section   <= csr_pwdata[0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (csr_idx)
         CSR_FUSE_LOW:  csr_prdata = 64'(cfg_ff.fuse_low);
         CSR_FUSE_HIGH: csr_prdata = 64'(cfg_ff.fuse_high);
         CSR_FUSE_EXT:  csr_prdata = 64'(cfg_ff.fuse_extended);
         CSR_LOCK:      csr_prdata = 64'(cfg_ff.lock_byte);
         CSR_SIGNATURE: csr_prdata = 64'(cfg_ff.device_signature);
         CSR_SERIAL_LO: csr_prdata = cfg_ff.serial_low_bytes;
         CSR_SERIAL_HI: csr_prdata = 64'(cfg_ff.serial_high_bytes);
         CSR_HAS_RWW:   csr_prdata = 64'(cfg_ff.has_rww_section);
         default:       csr_prdata = '0;
      endcase
   end

   fsp_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_kind  (req_kind),
      .req_ready (req_ready),
      .cmd       (cmd),
      .stat      (stat)
   );

   fsp_dpath #(
      .PAGE_WORDS (PAGE_WORDS)
   ) u_dpath (
      .clock             (clock),
      .reset             (reset),
      .req_ctrl_value    (req_ctrl_value),
      .req_z_address     (req_z_address),
      .req_r01_word      (req_r01_word),
      .cfg               (cfg_ff),
      .cmd               (cmd),
      .stat              (stat),
      .rsp_ready         (rsp_ready),
      .rsp_valid         (rsp_valid),
      .rsp_result_kind   (rsp_result_kind),
      .rsp_read_byte     (rsp_read_byte),
      .rsp_flash_address (rsp_flash_address),
      .rsp_write_word    (rsp_write_word),
      .rsp_last          (rsp_last)
   );

   a_lpm_blocks: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready && req_kind == KIND_LPM) |=> !req_ready)
      else $error("LPM beat did not hold off the next item");

   a_single_read: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_result_kind != RK_WORD_WRITE) |-> rsp_last)
      else $error("LPM result not marked last");

   a_arm: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready && req_kind == KIND_CTRL && req_ctrl_value[CB_ENABLE])
      |=> stat.ctrl_bits[CB_ENABLE])
      else $error("enable bit not armed by control write");

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (cmd.emit_load || cmd.lpm_load) |-> (!rsp_valid || rsp_ready))
      else $error("result register overwritten while waiting");

endmodule
`default_nettype wire

// File: tb/tb_flash_self_program_controller_core.sv
`timescale 1ns / 1ps
module tb_flash_self_program_controller_core;
   import fsp_pkg::*;

   localparam int PAGE_WORDS  = 64;
   localparam int SETTLE      = 24;
   localparam int CYCLE_LIMIT = 400000;
   localparam int PHASE_ITEMS = 60;
   localparam int MAX_PRINTS  = 40;

   localparam logic [2:0] REG_FUSE_LOW   = 3'd0;
   localparam logic [2:0] REG_FUSE_HIGH  = 3'd1;
   localparam logic [2:0] REG_FUSE_EXT   = 3'd2;
   localparam logic [2:0] REG_LOCK       = 3'd3;
   localparam logic [2:0] REG_SIGNATURE  = 3'd4;
   localparam logic [2:0] REG_SERIAL_LO  = 3'd5;
   localparam logic [2:0] REG_SERIAL_HI  = 3'd6;
   localparam logic [2:0] REG_HAS_RWW    = 3'd7;

   localparam logic [7:0] B_EN    = 8'h01 << CB_ENABLE;
   localparam logic [7:0] B_ERASE = 8'h01 << CB_ERASE;
   localparam logic [7:0] B_WRITE = 8'h01 << CB_WRITE;
   localparam logic [7:0] B_LOCK  = 8'h01 << CB_LOCKSET;
   localparam logic [7:0] B_SIG   = 8'h01 << CB_SIGREAD;

   typedef struct packed {
      logic [1:0]  kind;
      logic [7:0]  rbyte;
      logic [23:0] addr;
      logic [15:0] word;
      logic        last;
   } beat_type;

   typedef struct packed {
      logic [1:0]  kind;
      logic [7:0]  ctrl;
      logic [23:0] z;
      logic [15:0] r01;
      logic        typed;
      logic [1:0]  t_kind;
      logic [7:0]  t_byte;
   } item_type;

   logic        clock = 1'b0;
   logic        reset;
   logic        req_valid;
   logic        req_ready;
   logic [1:0]  req_kind;
   logic [7:0]  req_ctrl_value;
   logic [23:0] req_z_address;
   logic [15:0] req_r01_word;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [1:0]  rsp_result_kind;
   logic [7:0]  rsp_read_byte;
   logic [23:0] rsp_flash_address;
   logic [15:0] rsp_write_word;
   logic        rsp_last;
   logic        csr_psel;
   logic        csr_penable;
   logic        csr_pwrite;
   logic [5:0]  csr_paddr;
   logic [63:0] csr_pwdata;
   logic [63:0] csr_prdata;
   logic        csr_pready;

   flash_self_program_controller_core #(.PAGE_WORDS(PAGE_WORDS)) dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_kind(req_kind),
      .req_ctrl_value(req_ctrl_value), .req_z_address(req_z_address),
      .req_r01_word(req_r01_word),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_result_kind(rsp_result_kind),
      .rsp_read_byte(rsp_read_byte), .rsp_flash_address(rsp_flash_address),
      .rsp_write_word(rsp_write_word), .rsp_last(rsp_last),
      .csr_psel(csr_psel), .csr_penable(csr_penable), .csr_pwrite(csr_pwrite),
      .csr_paddr(csr_paddr), .csr_pwdata(csr_pwdata), .csr_prdata(csr_prdata),
      .csr_pready(csr_pready)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // controller state as predicted
   logic [7:0]  ctl_reg;
   logic [2:0]  arm_count;
   logic [15:0] page_data [PAGE_WORDS];
   logic        slot_taken [PAGE_WORDS];
   logic [7:0]  cfg_fuse_lo, cfg_fuse_hi, cfg_fuse_ext, cfg_lock;
   logic [23:0] cfg_sig;
   logic [63:0] cfg_ser_lo;
   logic [15:0] cfg_ser_hi;
   logic        cfg_rww;
   int          serial_order [10] = '{1, 0, 3, 2, 5, 4, 0, 6, 7, 8};

   beat_type due_beats [$];
   beat_type want_b, got_b;
   item_type dir_rows [$];

   int send_idle_pct = 0;
   int rsp_stall_pct = 0;
   int errors = 0;
   int items_sent = 0;
   int beats_checked = 0;
   int page_ops = 0;
   int overrides = 0;
   int cycle_count = 0;

   task automatic log_error(input string msg);
      errors++;
      if (errors <= MAX_PRINTS)
         $display("ERROR @%0t: %s", $time, msg);
   endtask

   task automatic clear_page();
      for (int i = 0; i < PAGE_WORDS; i++) begin
         page_data[i] = 16'hFFFF;
         slot_taken[i] = 1'b0;
      end
   endtask

   function automatic logic [7:0] serial_at(input int n);
      if (n < 8)
         return 8'(cfg_ser_lo >> (8 * n));
      return 8'(cfg_ser_hi >> (8 * (n - 8)));
   endfunction

   // work out the beats one accepted item causes and queue them
   task automatic advance_controller(input item_type it);
      logic        en;
      logic        hit;
      logic [7:0]  b;
      logic [23:0] a;
      int          s;
      en = ctl_reg[CB_ENABLE];
      hit = 1'b0;
      b = 8'h00;
      if (it.kind == KIND_CTRL) begin
         ctl_reg = it.ctrl;
         if (it.ctrl[CB_ENABLE])
            arm_count = ARM_TICKS;
      end else if (it.kind == KIND_TICK) begin
         if (arm_count != 0) begin
            arm_count = arm_count - 3'd1;
            if (arm_count == 0)
               ctl_reg[CB_ENABLE] = 1'b0;
         end
      end else begin
         if (it.kind == KIND_LPM) begin
            if (en && ctl_reg[CB_LOCKSET]) begin
               hit = 1'b1;
               case (it.z)
                  24'd0: b = cfg_fuse_lo;
                  24'd1: b = cfg_lock;
                  24'd2: b = cfg_fuse_ext;
                  24'd3: b = cfg_fuse_hi;
                  default: hit = 1'b0;
               endcase
            end else if (en && ctl_reg[CB_SIGREAD]) begin
               hit = 1'b1;
               if (it.z == 24'd0) b = cfg_sig[7:0];
               else if (it.z == 24'd2) b = cfg_sig[15:8];
               else if (it.z == 24'd4) b = cfg_sig[23:16];
               else if (it.z == 24'd1) b = OSC_CAL;
               else if (it.z >= SERIAL_FIRST && it.z <= SERIAL_FINAL)
                  b = serial_at(serial_order[int'(it.z - SERIAL_FIRST)]);
               else hit = 1'b0;
            end
            if (hit) overrides++;
            due_beats.push_back({hit ? RK_OVERRIDE : RK_FLASH_READ, hit ? b : 8'h00,
                                 24'h000000, 16'h0000, 1'b1});
         end else if (en) begin
            if (ctl_reg[CB_ERASE]) begin
               page_ops++;
               a = {it.z[23:1], 1'b0};
               for (int i = 0; i < PAGE_WORDS; i++) begin
                  due_beats.push_back({RK_WORD_WRITE, 8'h00, a, 16'hFFFF,
                                       1'(i == PAGE_WORDS - 1)});
                  a = a + 24'd2;
               end
            end else if (ctl_reg[CB_WRITE]) begin
               page_ops++;
               a = 24'(it.z - (it.z % (2 * PAGE_WORDS)));
               for (int i = 0; i < PAGE_WORDS; i++) begin
                  due_beats.push_back({RK_WORD_WRITE, 8'h00, a, page_data[i],
                                       1'(i == PAGE_WORDS - 1)});
                  a = a + 24'd2;
               end
               clear_page();
            end else if (ctl_reg[CB_LOCKSET]) begin
               // lock bit programming has no effect here
            end else if (cfg_rww && ctl_reg[CB_RWW]) begin
               clear_page();
            end else begin
               s = (it.z >> 1) % PAGE_WORDS;
               if (!slot_taken[s]) begin
                  page_data[s] = it.r01;
                  slot_taken[s] = 1'b1;
               end
            end
         end
         if (en)
            arm_count = 3'd0;
         ctl_reg[CB_ENABLE] = 1'b0;
      end
   endtask

   task automatic send_item(input item_type it);
      logic took;
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid      <= 1'b1;
      req_kind       <= it.kind;
      req_ctrl_value <= it.ctrl;
      req_z_address  <= it.z;
      req_r01_word   <= it.r01;
      do begin
         @(negedge clock);
         took = req_ready;
         @(posedge clock);
      end while (took !== 1'b1);
      advance_controller(it);
      // hand-typed rows: swap in the result typed into the row
      if (it.typed) begin
         void'(due_beats.pop_back());
         due_beats.push_back({it.t_kind, it.t_byte, 24'h000000, 16'h0000, 1'b1});
      end
      items_sent++;
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      do @(posedge clock); while (due_beats.size() != 0);
   endtask

   task automatic quiesce();
      drain();
      repeat (SETTLE) @(posedge clock);
   endtask

   // write one register, then read it back
   task automatic csr_access(input logic [2:0] idx, input logic [63:0] val);
      logic        rdy;
      logic [63:0] got;
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {idx, 3'b000};
      csr_pwdata  <= val;
      @(posedge clock);
      csr_penable <= 1'b1;
      do begin
         @(negedge clock);
         rdy = csr_pready;
         @(posedge clock);
      end while (rdy !== 1'b1);
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      @(posedge clock);
      csr_penable <= 1'b1;
      do begin
         @(negedge clock);
         rdy = csr_pready;
         got = csr_prdata;
         @(posedge clock);
      end while (rdy !== 1'b1);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      if (got !== val)
         log_error($sformatf("register %0d reads %h, wrote %h", idx, got, val));
   endtask

   task automatic write_all_regs(input logic [7:0] f_lo, input logic [7:0] f_hi,
                                 input logic [7:0] f_ext, input logic [7:0] lock,
                                 input logic [23:0] sig, input logic [63:0] ser_lo,
                                 input logic [15:0] ser_hi, input logic rww);
      cfg_fuse_lo = f_lo;
      cfg_fuse_hi = f_hi;
      cfg_fuse_ext = f_ext;
      cfg_lock = lock;
      cfg_sig = sig;
      cfg_ser_lo = ser_lo;
      cfg_ser_hi = ser_hi;
      cfg_rww = rww;
      csr_access(REG_FUSE_LOW, 64'(f_lo));
      csr_access(REG_FUSE_HIGH, 64'(f_hi));
      csr_access(REG_FUSE_EXT, 64'(f_ext));
      csr_access(REG_LOCK, 64'(lock));
      csr_access(REG_SIGNATURE, 64'(sig));
      csr_access(REG_SERIAL_LO, ser_lo);
      csr_access(REG_SERIAL_HI, 64'(ser_hi));
      csr_access(REG_HAS_RWW, 64'(rww));
   endtask

   function automatic item_type mk(input logic [1:0] k, input logic [7:0] c,
                                   input logic [23:0] z, input logic [15:0] r,
                                   input logic t, input logic [1:0] tk,
                                   input logic [7:0] tb);
      item_type it;
      it.kind = k;
      it.ctrl = c;
      it.z = z;
      it.r01 = r;
      it.typed = t;
      it.t_kind = tk;
      it.t_byte = tb;
      return it;
   endfunction

   function automatic item_type noise_item(input logic [1:0] k);
      item_type it;
      it = '0;
      it.kind = k;
      it.ctrl = 8'($urandom);
      it.z = 24'($urandom);
      it.r01 = 16'($urandom);
      return it;
   endfunction

   // mostly arm-then-use sequences, with stray ticks and loose noise beats
   task automatic random_burst(input int count, input int pause_at);
      int       issued;
      int       op;
      int       ticks;
      logic     paused;
      item_type it;
      issued = 0;
      paused = 1'b0;
      while (issued < count) begin
         if (!paused && pause_at >= 0 && issued >= pause_at) begin
            drain();
            paused = 1'b1;
         end
         if ($urandom_range(99) < 12) begin
            send_item(noise_item(2'($urandom_range(3))));
            issued++;
         end else begin
            op = $urandom_range(7);
            it = noise_item(KIND_CTRL);
            if (op != 7) begin
               it.ctrl = 8'h00;
               case (op)
                  0, 6: it.ctrl[CB_LOCKSET] = 1'b1;
                  1: it.ctrl[CB_SIGREAD] = 1'b1;
                  3: it.ctrl[CB_ERASE] = 1'b1;
                  4: it.ctrl[CB_WRITE] = 1'b1;
                  5: it.ctrl[CB_RWW] = 1'b1;
                  default: ;
               endcase
               it.ctrl[CB_ENABLE] = ($urandom_range(9) != 0);
               it.ctrl[7:6] = 2'($urandom_range(3));
            end
            send_item(it);
            issued++;
            ticks = ($urandom_range(9) < 6) ? 0 : $urandom_range(1, 5);
            repeat (ticks) begin
               send_item(noise_item(KIND_TICK));
               issued++;
            end
            if (op <= 1)
               it = noise_item(KIND_LPM);
            else if (op == 7)
               it = noise_item($urandom_range(1) ? KIND_LPM : KIND_SPM);
            else
               it = noise_item(KIND_SPM);
            if (op <= 1 && $urandom_range(3) != 0)
               it.z = 24'($urandom_range(24));
            else if ($urandom_range(3) == 0)
               it.z = 24'($urandom_range(31));
            send_item(it);
            issued++;
         end
      end
   endtask

   always @(posedge clock)
      rsp_ready <= ($urandom_range(99) >= rsp_stall_pct);

   // check each result beat on the falling edge before the edge that takes it
   always @(negedge clock) begin
      if (!reset && rsp_valid === 1'b1 && rsp_ready) begin
         got_b = {rsp_result_kind, rsp_read_byte, rsp_flash_address, rsp_write_word,
                  rsp_last};
         if (due_beats.size() == 0) begin
            log_error($sformatf("unexpected beat kind %0d byte %h addr %h word %h last %b",
                                got_b.kind, got_b.rbyte, got_b.addr, got_b.word,
                                got_b.last));
         end else begin
            want_b = due_beats.pop_front();
            beats_checked++;
            if (got_b !== want_b)
               log_error($sformatf({"beat %0d: got kind %0d byte %h addr %h word %h last %b,",
                                    " want kind %0d byte %h addr %h word %h last %b"},
                                   beats_checked, got_b.kind, got_b.rbyte, got_b.addr,
                                   got_b.word, got_b.last, want_b.kind, want_b.rbyte,
                                   want_b.addr, want_b.word, want_b.last));
         end
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("cycle limit reached with %0d beats outstanding", due_beats.size());
         $display("tb_flash_self_program_controller_core: errors");
         $finish;
      end
   end

   initial begin
      reset          <= 1'b1;
      req_valid      <= 1'b0;
      req_kind       <= KIND_TICK;
      req_ctrl_value <= 8'h00;
      req_z_address  <= 24'h000000;
      req_r01_word   <= 16'h0000;
      csr_psel       <= 1'b0;
      csr_penable    <= 1'b0;
      csr_pwrite     <= 1'b0;
      csr_paddr      <= 6'd0;
      csr_pwdata     <= 64'd0;

      ctl_reg = 8'h00;
      arm_count = 3'd0;
      clear_page();
      cfg_fuse_lo = 8'hFF;
      cfg_fuse_hi = 8'hFF;
      cfg_fuse_ext = 8'hFF;
      cfg_lock = 8'hFF;
      cfg_sig = 24'h000000;
      cfg_ser_lo = 64'd0;
      cfg_ser_hi = 16'h0000;
      cfg_rww = 1'b0;

      // directed rows, run against the reset values of the registers
      dir_rows.push_back(mk(KIND_LPM, 8'h00, 24'h000000, 16'h0000, 1'b1, RK_FLASH_READ, 8'h00));
      dir_rows.push_back(mk(KIND_CTRL, B_EN | B_LOCK, 24'h0, 16'h0, 1'b0, 2'd0, 8'h00));
      dir_rows.push_back(mk(KIND_LPM, 8'h00, 24'h000000, 16'h0000, 1'b1, RK_OVERRIDE, 8'hFF));
      dir_rows.push_back(mk(KIND_CTRL, B_EN | B_LOCK | B_SIG, 24'h0, 16'h0, 1'b0, 2'd0, 8'h00));
      dir_rows.push_back(mk(KIND_LPM, 8'h00, 24'h000004, 16'h0000, 1'b1, RK_FLASH_READ, 8'h00));
      dir_rows.push_back(mk(KIND_CTRL, B_EN | B_SIG, 24'h0, 16'h0, 1'b0, 2'd0, 8'h00));
      dir_rows.push_back(mk(KIND_LPM, 8'h00, 24'h000001, 16'h0000, 1'b1, RK_OVERRIDE, 8'h55));
      dir_rows.push_back(mk(KIND_CTRL, B_EN | B_SIG, 24'h0, 16'h0, 1'b0, 2'd0, 8'h00));
      dir_rows.push_back(mk(KIND_LPM, 8'h00, 24'h000017, 16'h0000, 1'b1, RK_OVERRIDE, 8'h00));
      // let the enable time out before the read
      dir_rows.push_back(mk(KIND_CTRL, B_EN | B_LOCK, 24'h0, 16'h0, 1'b0, 2'd0, 8'h00));
      repeat (4)
         dir_rows.push_back(mk(KIND_TICK, 8'h00, 24'h0, 16'h0, 1'b0, 2'd0, 8'h00));
      dir_rows.push_back(mk(KIND_LPM, 8'h00, 24'h000003, 16'h0000, 1'b1, RK_FLASH_READ, 8'h00));
      dir_rows.push_back(mk(KIND_CTRL, B_EN, 24'h0, 16'h0, 1'b0, 2'd0, 8'h00));
      dir_rows.push_back(mk(KIND_SPM, 8'h00, 24'h000002, 16'h0000, 1'b0, 2'd0, 8'h00));
      dir_rows.push_back(mk(KIND_SPM, 8'h00, 24'h000000, 16'hA5A5, 1'b0, 2'd0, 8'h00));
      dir_rows.push_back(mk(KIND_CTRL, B_EN | B_WRITE, 24'h0, 16'h0, 1'b0, 2'd0, 8'h00));
      dir_rows.push_back(mk(KIND_SPM, 8'hFF, 24'hFFFFFF, 16'hFFFF, 1'b0, 2'd0, 8'h00));
      dir_rows.push_back(mk(KIND_CTRL, B_EN | B_ERASE | B_WRITE, 24'h0, 16'h0, 1'b0, 2'd0, 8'h00));
      dir_rows.push_back(mk(KIND_SPM, 8'h00, 24'hFFFFFF, 16'h1234, 1'b0, 2'd0, 8'h00));
      dir_rows.push_back(mk(KIND_CTRL, B_EN | B_LOCK, 24'h0, 16'h0, 1'b0, 2'd0, 8'h00));
      dir_rows.push_back(mk(KIND_SPM, 8'h00, 24'h123456, 16'h5A5A, 1'b0, 2'd0, 8'h00));

      repeat (3) @(posedge clock);
      reset <= 1'b0;

      foreach (dir_rows[i])
         send_item(dir_rows[i]);
      quiesce();

      // all ones, no idling, one pause for the pipeline to empty
      write_all_regs(8'hFF, 8'hFF, 8'hFF, 8'hFF, 24'hFFFFFF, {64{1'b1}}, 16'hFFFF, 1'b1);
      random_burst(PHASE_ITEMS, PHASE_ITEMS / 2);
      quiesce();

      write_all_regs(8'h00, 8'h00, 8'h00, 8'h00, 24'h000000, 64'd0, 16'h0000, 1'b0);
      send_idle_pct = 74;
      random_burst(PHASE_ITEMS, -1);
      quiesce();

      write_all_regs(8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom),
                     24'($urandom), {$urandom, $urandom}, 16'($urandom), 1'b1);
      send_idle_pct = 0;
      rsp_stall_pct = 74;
      random_burst(PHASE_ITEMS, -1);
      quiesce();

      write_all_regs(8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom),
                     24'($urandom), {$urandom, $urandom}, 16'($urandom),
                     1'($urandom_range(1)));
      send_idle_pct = 30;
      rsp_stall_pct = 30;
      random_burst(PHASE_ITEMS, -1);
      quiesce();

      if (due_beats.size() != 0)
         log_error($sformatf("%0d beats never arrived", due_beats.size()));
      $display("%0d items sent, %0d result beats checked, %0d page erases/writes, %0d overrides",
               items_sent, beats_checked, page_ops, overrides);
      $display("register sets: reset, all ones, all zeros, two random; idling: off, %s",
               "sender, receiver, both");
      if (errors == 0)
         $display("tb_flash_self_program_controller_core: clean");
      else
         $display("tb_flash_self_program_controller_core: errors");
      $finish;
   end

endmodule

// File: flash_self_program_controller_core.f
rtl/core/fsp_pkg.sv
rtl/core/fsp_ctrl.sv
rtl/core/fsp_dpath.sv
rtl/core/flash_self_program_controller_core.sv
tb/tb_flash_self_program_controller_core.sv
